FILE: design/barometric_sensor_compensation_assert.svh
// Assertion macros shared by the compensation block checkers
`ifndef BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH

// Clocked assertion with active-low reset disable
`define BSC_ASSERT(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion: consequent checked in the cycle after the antecedent
`define BSC_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) ante |=> cons) else $error(msg);

`endif

FILE: design/bsc_pkg.sv
// Package: types and constants for the barometric compensation block
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned SAMPLE_W = 20;
  localparam int unsigned RESULT_W = 32;
  localparam int unsigned CFG_IDX_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIM  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_HIGH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LAST = 8'd3;

  // Operation codes
  localparam logic OP_TEMP  = 1'b0;
  localparam logic OP_PRESS = 1'b1;

  // Compensation constants
  localparam logic [DATA_W-1:0] FINE_OFFSET = 64'd128000;
  localparam logic [DATA_W-1:0] PRESS_BASE  = 64'd1048576;
  localparam logic [DATA_W-1:0] NUM_SCALE   = 64'd3125;
  localparam logic [DATA_W-1:0] BIAS_47     = 64'h0000_8000_0000_0000;
  localparam logic [DATA_W-1:0] TEMP_MUL    = 64'd5;
  localparam logic [31:0]       TEMP_ROUND  = 32'd128;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FIN
  } state_t;

  // Multiply steps of the sequencer
  typedef enum logic [3:0] {
    S_PA, S_PV2, S_PV5, S_PP3, S_PP2, S_PP1, S_PNUM,
    S_PP9A, S_PP9B, S_PP8,
    S_TA, S_TB, S_TC, S_TD
  } step_t;

  // 16-bit trim word sign-extended to 64 bits
  function automatic logic [DATA_W-1:0] sx16(input logic [15:0] w);
    sx16 = {{48{w[15]}}, w};
  endfunction

  // 32-bit value sign-extended to 64 bits
  function automatic logic [DATA_W-1:0] sx32(input logic [31:0] w);
    sx32 = {{32{w[31]}}, w};
  endfunction

endpackage
`default_nettype wire

FILE: design/bsc_mul.sv
// Iterative 64x64 multiplier, low 64 bits, on one 32x32 multiplier over three partial products
`timescale 1ns / 1ps
`default_nettype none
module bsc_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] op_a,
  input  wire logic [63:0] op_b,
  output logic             done,
  output logic [63:0]      prod
);

  logic [63:0] a_r, b_r, acc_r;
  logic [1:0]  phase_r;
  logic        busy_r, done_r;
  logic [31:0] mx, my;
  logic [63:0] m;

  // Partial product select: lo*lo, lo*hi, hi*lo
  always_comb begin
    case (phase_r)
      2'd0:    begin mx = a_r[31:0];  my = b_r[31:0];  end
      2'd1:    begin mx = a_r[31:0];  my = b_r[63:32]; end
      default: begin mx = a_r[63:32]; my = b_r[31:0];  end
    endcase
    m = mx * my;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 2'd0;
      end else if (busy_r) begin
        if (phase_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        phase_r <= phase_r + 2'd1;
      end
    end
  end

  // Operands and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= op_a;
      b_r <= op_b;
    end else if (busy_r) begin
      if (phase_r == 2'd0) acc_r <= m;
      else                 acc_r <= acc_r + {m[31:0], 32'd0};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

FILE: design/bsc_div.sv
// Signed 64-bit restoring divider, truncating toward zero, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module bsc_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             done,
  output logic [63:0]      quot
);

  logic [63:0] den_r, rem_r, quo_r, q_out_r;
  logic [5:0]  cnt_r;
  logic        neg_r, busy_r, done_r;
  logic [64:0] trial;
  logic [63:0] rem_nxt, quo_nxt;
  logic        fits;

  // One restoring step
  always_comb begin
    trial   = {rem_r, quo_r[63]} - {1'b0, den_r};
    fits    = !trial[64];
    rem_nxt = fits ? trial[63:0] : {rem_r[62:0], quo_r[63]};
    quo_nxt = {quo_r[62:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Magnitudes, shift, and final sign fix
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num[63] ? 64'd0 - num : num;
      den_r <= den[63] ? 64'd0 - den : den;
      rem_r <= '0;
      neg_r <= num[63] ^ den[63];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      if (cnt_r == 6'd0) q_out_r <= neg_r ? 64'd0 - quo_nxt : quo_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_out_r;

endmodule
`default_nettype wire

FILE: design/barometric_sensor_compensation.sv
// Top level: barometric temperature and pressure compensation
`timescale 1ns / 1ps
`default_nettype none
// Compensates raw 20-bit samples with the standard 64-bit integer scheme.
// One item is handled at a time; in_tready is high only while idle. Each
// multiply on the shared 32x32 multiplier goes through start, three
// partial products and done. A temperature item runs four multiplies
// between the accept and finish states. A pressure item runs ten
// multiplies plus the bit-serial divide; with a zero divisor it ends
// after six multiplies. A stalled result register extends the finish
// state. Temperature items update the stored fine temperature used by
// later pressure items. A zero divisor returns value 0 with the error
// flag set. The result register frees the input side once loaded.
module barometric_sensor_compensation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [19:0] raw_sample, [23:20] zero
  input  wire logic [0:0]  in_tuser,   // [0] operation
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] value
  output logic [1:0]       out_tuser,  // [0] kind, [1] error
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  bsc_pkg::state_t state_r, state_nxt;
  bsc_pkg::step_t  step_r;

  logic [47:0] temp_trim_r;
  logic [63:0] plo_r, phi_r;
  logic [15:0] plast_r;
  logic [31:0] fine_r;

  logic        kind_r, err_r;
  logic [19:0] adc_r;
  logic [63:0] v1_r, v2_r, a_r, p_r;

  logic        out_valid_r, out_kind_r, out_err_r;
  logic [31:0] out_value_r;

  logic        in_acc, out_free;
  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_b, prod, quot;
  logic [63:0] p_sh13, v1_p1, fin_sum, fin_val;
  logic [31:0] t_a, t_b, tc_fine;
  logic        last_mul;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_trim_r <= '0;
      plo_r       <= '0;
      phi_r       <= '0;
      plast_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bsc_pkg::REG_TEMP_TRIM:  temp_trim_r <= cfg_data[47:0];
        bsc_pkg::REG_PRESS_LOW:  plo_r       <= cfg_data;
        bsc_pkg::REG_PRESS_HIGH: phi_r       <= cfg_data;
        bsc_pkg::REG_PRESS_LAST: plast_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Shared units
  bsc_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start),
    .op_a(mul_a), .op_b(mul_b), .done(mul_done), .prod(prod)
  );

  bsc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(a_r), .den(v1_r), .done(div_done), .quot(quot)
  );

  // Multiplier operand select per step
  assign p_sh13 = 64'($signed(p_r) >>> 13);
  always_comb begin
    case (step_r)
      bsc_pkg::S_PA:   begin mul_a = v1_r; mul_b = v1_r; end
      bsc_pkg::S_PV2:  begin mul_a = a_r;  mul_b = bsc_pkg::sx16(phi_r[31:16]); end
      bsc_pkg::S_PV5:  begin mul_a = v1_r; mul_b = bsc_pkg::sx16(phi_r[15:0]); end
      bsc_pkg::S_PP3:  begin mul_a = a_r;  mul_b = bsc_pkg::sx16(plo_r[47:32]); end
      bsc_pkg::S_PP2:  begin mul_a = v1_r; mul_b = bsc_pkg::sx16(plo_r[31:16]); end
      bsc_pkg::S_PP1:  begin mul_a = v1_r; mul_b = {48'd0, plo_r[15:0]}; end
      bsc_pkg::S_PNUM: begin mul_a = (p_r << 31) - v2_r; mul_b = bsc_pkg::NUM_SCALE; end
      bsc_pkg::S_PP9A: begin mul_a = bsc_pkg::sx16(plast_r); mul_b = p_sh13; end
      bsc_pkg::S_PP9B: begin mul_a = v1_r; mul_b = p_sh13; end
      bsc_pkg::S_PP8:  begin mul_a = bsc_pkg::sx16(phi_r[63:48]); mul_b = p_r; end
      bsc_pkg::S_TA:   begin mul_a = v1_r; mul_b = bsc_pkg::sx16(temp_trim_r[31:16]); end
      bsc_pkg::S_TB:   begin mul_a = v2_r; mul_b = v2_r; end
      bsc_pkg::S_TC:   begin mul_a = v2_r; mul_b = bsc_pkg::sx16(temp_trim_r[47:32]); end
      default:         begin mul_a = v1_r; mul_b = bsc_pkg::TEMP_MUL; end
    endcase
  end

  assign v1_p1    = 64'($signed(prod) >>> 33);
  assign last_mul = (step_r == bsc_pkg::S_PP8) || (step_r == bsc_pkg::S_TD);
  assign tc_fine  = a_r[31:0] + 32'($signed(prod[31:0]) >>> 14);

  // Temperature operands on entry
  assign t_a = {15'd0, in_tdata[19:3]} - {15'd0, temp_trim_r[15:0], 1'b0};
  assign t_b = {16'd0, in_tdata[19:4]} - {16'd0, temp_trim_r[15:0]};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsc_pkg::ST_IDLE:     if (in_acc) state_nxt = bsc_pkg::ST_MUL_GO;
      bsc_pkg::ST_MUL_GO:   state_nxt = bsc_pkg::ST_MUL_WAIT;
      bsc_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          if (last_mul) state_nxt = bsc_pkg::ST_FIN;
          else if (step_r == bsc_pkg::S_PP1 && v1_p1 == 64'd0) state_nxt = bsc_pkg::ST_FIN;
          else if (step_r == bsc_pkg::S_PNUM) state_nxt = bsc_pkg::ST_DIV_GO;
          else state_nxt = bsc_pkg::ST_MUL_GO;
        end
      end
      bsc_pkg::ST_DIV_GO:   state_nxt = bsc_pkg::ST_DIV_WAIT;
      bsc_pkg::ST_DIV_WAIT: if (div_done) state_nxt = bsc_pkg::ST_MUL_GO;
      bsc_pkg::ST_FIN:      if (out_free) state_nxt = bsc_pkg::ST_IDLE;
      default:              state_nxt = bsc_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      bsc_pkg::ST_IDLE:   in_tready = 1'b1;
      bsc_pkg::ST_MUL_GO: mul_start = 1'b1;
      bsc_pkg::ST_DIV_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bsc_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Final pressure combine
  assign fin_sum = p_r + v1_r + v2_r;
  assign fin_val = err_r ? 64'd0
                 : 64'($signed(fin_sum) >>> 8) + (bsc_pkg::sx16(phi_r[47:32]) << 4);

  // Fine temperature state
  always_ff @(posedge clk) begin
    if (!rst_n) fine_r <= '0;
    else if (state_r == bsc_pkg::ST_MUL_WAIT && mul_done && step_r == bsc_pkg::S_TC)
      fine_r <= tc_fine;
  end

  // Datapath registers and step sequencing
  always_ff @(posedge clk) begin
    if (state_r == bsc_pkg::ST_IDLE && in_acc) begin
      kind_r <= in_tuser[0];
      adc_r  <= in_tdata[19:0];
      err_r  <= 1'b0;
      if (in_tuser[0] == bsc_pkg::OP_PRESS) begin
        v1_r   <= bsc_pkg::sx32(fine_r) - bsc_pkg::FINE_OFFSET;
        step_r <= bsc_pkg::S_PA;
      end else begin
        v1_r   <= bsc_pkg::sx32(t_a);
        v2_r   <= bsc_pkg::sx32(t_b);
        step_r <= bsc_pkg::S_TA;
      end
    end else if (state_r == bsc_pkg::ST_DIV_WAIT && div_done) begin
      p_r    <= quot;
      step_r <= bsc_pkg::S_PP9A;
    end else if (state_r == bsc_pkg::ST_MUL_WAIT && mul_done) begin
      case (step_r)
        bsc_pkg::S_PA:   begin a_r <= prod; step_r <= bsc_pkg::S_PV2; end
        bsc_pkg::S_PV2:  begin v2_r <= prod; step_r <= bsc_pkg::S_PV5; end
        bsc_pkg::S_PV5:  begin
          v2_r   <= v2_r + (prod << 17) + (bsc_pkg::sx16(plo_r[63:48]) << 35);
          step_r <= bsc_pkg::S_PP3;
        end
        bsc_pkg::S_PP3:  begin a_r <= 64'($signed(prod) >>> 8); step_r <= bsc_pkg::S_PP2; end
        bsc_pkg::S_PP2:  begin
          v1_r   <= a_r + (prod << 12) + bsc_pkg::BIAS_47;
          step_r <= bsc_pkg::S_PP1;
        end
        bsc_pkg::S_PP1:  begin
          v1_r   <= v1_p1;
          err_r  <= (v1_p1 == 64'd0);
          p_r    <= bsc_pkg::PRESS_BASE - {44'd0, adc_r};
          step_r <= bsc_pkg::S_PNUM;
        end
        bsc_pkg::S_PNUM: a_r <= prod;
        bsc_pkg::S_PP9A: begin v1_r <= prod; step_r <= bsc_pkg::S_PP9B; end
        bsc_pkg::S_PP9B: begin v1_r <= 64'($signed(prod) >>> 25); step_r <= bsc_pkg::S_PP8; end
        bsc_pkg::S_PP8:  v2_r <= 64'($signed(prod) >>> 19);
        bsc_pkg::S_TA:   begin
          a_r    <= bsc_pkg::sx32(32'($signed(prod[31:0]) >>> 11));
          step_r <= bsc_pkg::S_TB;
        end
        bsc_pkg::S_TB:   begin
          v2_r   <= bsc_pkg::sx32(32'($signed(prod[31:0]) >>> 12));
          step_r <= bsc_pkg::S_TC;
        end
        bsc_pkg::S_TC:   begin v1_r <= bsc_pkg::sx32(tc_fine); step_r <= bsc_pkg::S_TD; end
        default:
          v1_r <= bsc_pkg::sx32(32'($signed(prod[31:0] + bsc_pkg::TEMP_ROUND) >>> 8));
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == bsc_pkg::ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bsc_pkg::ST_FIN && out_free) begin
      out_kind_r  <= kind_r;
      out_err_r   <= err_r;
      out_value_r <= (kind_r == bsc_pkg::OP_PRESS) ? fin_val[31:0] : v1_r[31:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = {out_err_r, out_kind_r};

endmodule
`default_nettype wire

FILE: design/bsc_checker.sv
// Port-level checker for the compensation block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "barometric_sensor_compensation_assert.svh"
module bsc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // one item at a time: no new transaction right after one is taken
  `BSC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, (in_tvalid && in_tready), !in_tready, "ready after accept")
  // a result takes work: an accept is never answered by an immediate result
  `BSC_ASSERT_NEXT(a_no_instant_result, clk, rst_n, (in_tvalid && in_tready), !$rose(out_tvalid), "result too early")
  // error only on pressure, with value zero
  `BSC_ASSERT(a_err_pressure_zero, clk, rst_n, (out_tvalid && out_tuser[1]) |-> (out_tuser[0] && out_tdata == 32'd0), "bad error result")
  // stalled result holds
  `BSC_ASSERT_NEXT(a_out_hold, clk, rst_n, (out_tvalid && !out_tready), (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "result changed under stall")

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
`default_nettype wire
